### hw/rtl/amt_pkg.sv
// Shared types, constants and reset values for the awareness message trigger.
package amt_pkg;

  // Position width in bits (two's complement, centimetres).
  localparam int POS_BITS = 28;
  // Width of a squared position difference; the sum of two squares is one bit wider.
  localparam int POS_SQ_BITS = 2 * POS_BITS;
  localparam int DIST_BITS = POS_SQ_BITS + 1;

  // The low-frequency container is added to a message once this long has passed since it was last carried.
  localparam logic [31:0] LOW_FREQ_PERIOD_MS = 32'd500;

  // Heading arithmetic, tenths of a degree.
  localparam logic [11:0] HDG_FULL = 12'd3600;
  localparam logic [11:0] HDG_HALF = 12'd1800;

  // Saturation value of the low-dynamics counter.
  localparam logic [7:0] LOW_DYN_MAX = 8'hFF;

  // Reset values of the configuration registers.
  localparam logic [15:0] MIN_INTERVAL_RST      = 16'd100;
  localparam logic [15:0] MAX_INTERVAL_RST      = 16'd1000;
  localparam logic [10:0] HEADING_THRESHOLD_RST = 11'd40;
  localparam logic [15:0] POSITION_THRESH_RST   = 16'd400;
  localparam logic [15:0] SPEED_THRESHOLD_RST   = 16'd50;
  localparam logic        CONGESTION_EN_RST     = 1'b1;
  localparam logic        FIXED_RATE_RST        = 1'b0;
  localparam logic [7:0]  LOW_DYN_LIMIT_RST     = 8'd3;

  // Reset value of the adaptive generation interval.
  localparam logic [15:0] GEN_INTERVAL_RST = 16'd1000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MIN_INTERVAL  = 3'd0,
    REG_MAX_INTERVAL  = 3'd1,
    REG_HEADING_THR   = 3'd2,
    REG_POSITION_THR  = 3'd3,
    REG_SPEED_THR     = 3'd4,
    REG_CONGESTION_EN = 3'd5,
    REG_FIXED_RATE    = 3'd6,
    REG_LOW_DYN_LIMIT = 3'd7
  } cfg_reg_t;

  // Reason for generating a message.
  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_FIXED    = 2'd1,
    CAUSE_DYNAMICS = 2'd2,
    CAUSE_TIMEOUT  = 2'd3
  } cause_t;

  typedef struct packed {
    logic [15:0] min_interval_ms;
    logic [15:0] max_interval_ms;
    logic [10:0] heading_threshold;
    logic [15:0] position_threshold_cm;
    logic [15:0] speed_threshold;
    logic        congestion_enable;
    logic        fixed_rate;
    logic [7:0]  low_dynamics_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0]                last_send_time;
    logic [31:0]                last_low_time;
    logic                       low_pending;
    logic signed [POS_BITS-1:0] last_x;
    logic signed [POS_BITS-1:0] last_y;
    logic signed [15:0]         last_speed;
    logic [11:0]                last_heading;
    logic [15:0]                gen_interval;
    logic [7:0]                 low_dyn_count;
  } state_t;

  typedef struct packed {
    logic [31:0]                now_ms;
    logic signed [POS_BITS-1:0] pos_x_cm;
    logic signed [POS_BITS-1:0] pos_y_cm;
    logic signed [15:0]         speed_cms;
    logic [11:0]                heading_ddeg;
    logic [15:0]                congestion_delay_ms;
  } in_item_t;

  typedef struct packed {
    logic        send;
    logic        with_low_freq;
    cause_t      cause;
    logic [15:0] interval_ms;
  } out_item_t;

endpackage

### hw/rtl/awareness_message_trigger_core.sv
// A tick accepted into the input register passes through the decision logic into the output register.
// Throughput: one tick per cycle while the output is not stalled; the state update is combinational decision logic.
// The output register and the input register let a new tick enter while a result waits.
// Reset (rst, synchronous, active high) empties both registers, restores the configuration
// defaults and clears the history, with the interval at 1000 ms and the low-frequency flag armed.
module awareness_message_trigger_core
  import amt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,

  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,

  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg;
  state_t    st;
  state_t    st_next;
  in_item_t  in_q;
  logic      in_q_valid;
  out_item_t res;
  logic      advance;

  // Configuration writes are always taken; the user must keep the block idle while they arrive (unchecked).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval_ms       <= MIN_INTERVAL_RST;
      cfg.max_interval_ms       <= MAX_INTERVAL_RST;
      cfg.heading_threshold     <= HEADING_THRESHOLD_RST;
      cfg.position_threshold_cm <= POSITION_THRESH_RST;
      cfg.speed_threshold       <= SPEED_THRESHOLD_RST;
      cfg.congestion_enable     <= CONGESTION_EN_RST;
      cfg.fixed_rate            <= FIXED_RATE_RST;
      cfg.low_dynamics_limit    <= LOW_DYN_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_INTERVAL:  cfg.min_interval_ms       <= cfg_data;
        REG_MAX_INTERVAL:  cfg.max_interval_ms       <= cfg_data;
        REG_HEADING_THR:   cfg.heading_threshold     <= cfg_data[10:0];
        REG_POSITION_THR:  cfg.position_threshold_cm <= cfg_data;
        REG_SPEED_THR:     cfg.speed_threshold       <= cfg_data;
        REG_CONGESTION_EN: cfg.congestion_enable     <= cfg_data[0];
        REG_FIXED_RATE:    cfg.fixed_rate            <= cfg_data[0];
        REG_LOW_DYN_LIMIT: cfg.low_dynamics_limit    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The decision stage moves its result on whenever the output register is
  // free or is being emptied in this cycle. The input register refills in the
  // same cycle, so a steady stream runs at one transaction per clock while the output is not stalled.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  amt_decide u_decide (
    .cfg     (cfg),
    .st      (st),
    .item    (in_q),
    .res     (res),
    .st_next (st_next)
  );

  // The history only moves when the tick in the input register is retired
  // into the output register, so every tick sees the state its predecessor
  // left behind.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.last_send_time <= '0;
      st.last_low_time  <= '0;
      st.low_pending    <= 1'b1;
      st.last_x         <= '0;
      st.last_y         <= '0;
      st.last_speed     <= '0;
      st.last_heading   <= '0;
      st.gen_interval   <= GEN_INTERVAL_RST;
      st.low_dyn_count  <= '0;
    end else if (in_q_valid && advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_q_valid && advance) begin
      out_data <= res;
    end
  end

endmodule

### hw/rtl/amt_decide.sv
// Single-pass send decision and state update for one tick.
module amt_decide
  import amt_pkg::*;
(
  input  cfg_t      cfg,
  input  state_t    st,
  input  in_item_t  item,
  output out_item_t res,
  output state_t    st_next
);

  logic [31:0]          elapsed;
  logic [15:0]          gap_lo;
  logic [15:0]          gap;
  logic                 gap_ok;

  logic [11:0]          hd_raw;
  logic [11:0]          hd_mod;
  logic [11:0]          hd_fold;
  logic                 hdg_trig;

  logic signed [POS_BITS:0] dx_diff;
  logic signed [POS_BITS:0] dy_diff;
  logic [POS_BITS-1:0]  dx_abs;
  logic [POS_BITS-1:0]  dy_abs;
  logic [POS_SQ_BITS-1:0] dx_sq;
  logic [POS_SQ_BITS-1:0] dy_sq;
  logic [DIST_BITS-1:0] dist_sq;
  logic [31:0]          thr_sq;
  logic                 pos_trig;

  logic signed [16:0]   sd_diff;
  logic [15:0]          sd_abs;
  logic                 spd_trig;

  logic                 dyn;
  logic [7:0]           cnt_inc;
  logic [31:0]          low_age;
  cause_t               cause;
  logic                 send;
  logic                 lowf;

  assign elapsed = item.now_ms - st.last_send_time;

  // Minimum gap: congestion delay clamped to the interval bounds, max wins; with congestion off, the minimum interval.
  always_comb begin
    gap_lo = (item.congestion_delay_ms > cfg.min_interval_ms) ?
             item.congestion_delay_ms : cfg.min_interval_ms;
    if (cfg.congestion_enable) begin
      gap = (gap_lo > cfg.max_interval_ms) ? cfg.max_interval_ms : gap_lo;
    end else begin
      gap = cfg.min_interval_ms;
    end
  end

  assign gap_ok = (elapsed >= {16'd0, gap});

  // Heading change, folded onto the shorter way round the circle.
  always_comb begin
    hd_raw  = (item.heading_ddeg > st.last_heading) ?
              (item.heading_ddeg - st.last_heading) :
              (st.last_heading - item.heading_ddeg);
    hd_mod  = (hd_raw >= HDG_FULL) ? (hd_raw - HDG_FULL) : hd_raw;
    hd_fold = (hd_mod > HDG_HALF) ? (HDG_FULL - hd_mod) : hd_mod;
  end

  assign hdg_trig = (hd_fold > {1'b0, cfg.heading_threshold});

  // Distance moved, compared as squares so no root is needed.
  assign dx_diff = {item.pos_x_cm[POS_BITS-1], item.pos_x_cm} -
                   {st.last_x[POS_BITS-1], st.last_x};
  assign dy_diff = {item.pos_y_cm[POS_BITS-1], item.pos_y_cm} -
                   {st.last_y[POS_BITS-1], st.last_y};

  always_comb begin
    logic [POS_BITS:0] dx_neg;
    logic [POS_BITS:0] dy_neg;
    dx_neg = -dx_diff;
    dy_neg = -dy_diff;
    dx_abs = dx_diff[POS_BITS] ? dx_neg[POS_BITS-1:0] : dx_diff[POS_BITS-1:0];
    dy_abs = dy_diff[POS_BITS] ? dy_neg[POS_BITS-1:0] : dy_diff[POS_BITS-1:0];
  end

  assign dx_sq   = {{POS_BITS{1'b0}}, dx_abs} * {{POS_BITS{1'b0}}, dx_abs};
  assign dy_sq   = {{POS_BITS{1'b0}}, dy_abs} * {{POS_BITS{1'b0}}, dy_abs};
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign thr_sq  = {16'd0, cfg.position_threshold_cm} *
                   {16'd0, cfg.position_threshold_cm};
  assign pos_trig = (dist_sq > {{(DIST_BITS-32){1'b0}}, thr_sq});

  // Speed change.
  assign sd_diff = {item.speed_cms[15], item.speed_cms} -
                   {st.last_speed[15], st.last_speed};

  always_comb begin
    logic [16:0] sd_neg;
    sd_neg = -sd_diff;
    sd_abs = sd_diff[16] ? sd_neg[15:0] : sd_diff[15:0];
  end

  assign spd_trig = (sd_abs > cfg.speed_threshold);
  assign dyn      = hdg_trig || pos_trig || spd_trig;

  assign cnt_inc = (st.low_dyn_count != LOW_DYN_MAX) ?
                   (st.low_dyn_count + 8'd1) : st.low_dyn_count;
  assign low_age = item.now_ms - st.last_low_time;

  always_comb begin
    st_next = st;
    cause   = CAUSE_NONE;
    if (gap_ok) begin
      if (cfg.fixed_rate) begin
        cause = CAUSE_FIXED;
      end else if (dyn) begin
        cause = CAUSE_DYNAMICS;
        st_next.gen_interval  = (elapsed < {16'd0, cfg.max_interval_ms}) ?
                                elapsed[15:0] : cfg.max_interval_ms;
        st_next.low_dyn_count = '0;
      end else if (elapsed >= {16'd0, st.gen_interval}) begin
        cause = CAUSE_TIMEOUT;
        st_next.low_dyn_count = cnt_inc;
        if (cnt_inc >= cfg.low_dynamics_limit) begin
          st_next.gen_interval = cfg.max_interval_ms;
        end
      end
    end

    send = (cause != CAUSE_NONE);
    lowf = send && (st.low_pending || (low_age >= LOW_FREQ_PERIOD_MS));

    if (send) begin
      st_next.last_x         = item.pos_x_cm;
      st_next.last_y         = item.pos_y_cm;
      st_next.last_speed     = item.speed_cms;
      st_next.last_heading   = item.heading_ddeg;
      st_next.last_send_time = item.now_ms;
    end
    if (lowf) begin
      st_next.last_low_time = item.now_ms;
      st_next.low_pending   = 1'b0;
    end
  end

  always_comb begin
    res.send          = send;
    res.with_low_freq = lowf;
    res.cause         = cause;
    res.interval_ms   = st_next.gen_interval;
  end

endmodule

### hw/rtl/amt_checker.sv
// Port-level checks for the awareness message trigger, bound to the top level.
module amt_checker
  import amt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_input_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_no_send_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.send |-> !out_data.with_low_freq && out_data.cause == CAUSE_NONE)
    else $error("fields set on a tick without a message");

  a_send_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.send |-> out_data.cause != CAUSE_NONE)
    else $error("message without a cause");

endmodule

bind awareness_message_trigger_core amt_checker u_amt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
